@@ rtl/radar_service_record_parser_macros.svh @@
// Assertion macros shared by the record parser RTL.
// No dependencies; include by bare file name.
`ifndef RADAR_SERVICE_RECORD_PARSER_MACROS_SVH
`define RADAR_SERVICE_RECORD_PARSER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RSRP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the following cycle.
`define RSRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rsrp_pkg.sv @@
// Package for the radar service record parser: word types and code constants.
// No dependencies.
package rsrp_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_ELEM = 2'd0;
    localparam logic [1:0] KIND_ERR  = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Element codes.
    localparam logic [3:0] EL_SRC_AREA = 4'd0;
    localparam logic [3:0] EL_SRC_ID   = 4'd1;
    localparam logic [3:0] EL_MSG_TYPE = 4'd2;
    localparam logic [3:0] EL_SECTOR   = 4'd3;
    localparam logic [3:0] EL_TIME     = 4'd4;
    localparam logic [3:0] EL_SPEED    = 4'd5;
    localparam logic [3:0] EL_CONFIG   = 4'd6;
    localparam logic [3:0] EL_MODE     = 4'd7;
    localparam logic [3:0] EL_PLOTS    = 4'd8;
    localparam logic [3:0] EL_RNG_ERR  = 4'd9;
    localparam logic [3:0] EL_AZ_ERR   = 4'd10;
    localparam logic [3:0] EL_WIN_BASE = 4'd11;
    localparam logic [3:0] EL_WARN     = 4'd15;

    // Error codes.
    localparam logic [2:0] ERR_NO_SRC    = 3'd0;
    localparam logic [2:0] ERR_NO_MSG    = 3'd1;
    localparam logic [2:0] ERR_NO_SECTOR = 3'd2;
    localparam logic [2:0] ERR_NO_WINDOW = 3'd3;
    localparam logic [2:0] ERR_EARLY_END = 3'd4;

    // Register reset value.
    localparam logic [7:0] BLIND_ZONE_RESET = 8'd8;

    // Output buffer geometry.
    localparam int OBUF_DEPTH = 8;
    localparam int OBUF_AW    = 3;
    localparam int MAX_RES    = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       record_end;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  element_code;
        logic [23:0] element_value;
        logic [4:0]  plot_ident;
        logic        antenna_flag;
        logic [2:0]  error_code;
        logic        last_in_item;
    } out_word_t;

endpackage

@@ rtl/radar_service_record_parser.sv @@
// Radar service record parser top level: byte decoder and output buffer.
// Depends on rsrp_pkg and radar_service_record_parser_macros.svh.
//
//   channel | direction | handshake          | word
//   in      | input     | in_valid/in_ready  | in_word_t (data_byte, record_end)
//   out     | output    | out_valid/out_ready| out_word_t (one result)
//   cfg     | input     | cfg_we             | cfg_data (blind_zone_msg_code)
//
// Each accepted byte is decoded in the cycle it is accepted; its zero to four
// results are written into an eight-word output buffer at once.
// One result leaves per cycle while out_ready is high; a byte is taken while four
// buffer words are free, so bytes flow at one per cycle only while the buffer keeps that room.
// Reset is asynchronous and active low; it empties the buffer and clears the
// record state, and sets blind_zone_msg_code to 8.
`include "radar_service_record_parser_macros.svh"

module radar_service_record_parser
    import rsrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data,
    input  logic      cfg_we,
    input  logic [7:0] cfg_data
);

    typedef enum logic [1:0] {
        PH_PRESENCE,
        PH_ITEMS,
        PH_DONE,
        PH_ABANDON
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] slot;
        logic [3:0] errs;
    } seek_t;

    // Record state.
    phase_t      phase_reg, phase_next;
    logic [13:0] pres_reg, pres_next;
    logic [3:0]  slot_reg, slot_next;
    logic [2:0]  bidx_reg, bidx_next;
    logic [23:0] acc_reg, acc_next;
    logic [7:0]  rep_reg, rep_next;
    logic [7:0]  mk_reg, mk_next;
    logic [7:0]  bz_reg;

    // Output buffer.
    out_word_t           obuf [OBUF_DEPTH];
    logic [OBUF_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [OBUF_AW:0]    cnt_reg;

    logic        in_acc, out_pop;
    out_word_t   res_list [MAX_RES];
    logic [2:0]  res_n;

    // Find the next present item at or after a field, skipping field 12, and report missing items that raise errors.
    function automatic seek_t seek_fn(input logic [3:0] from, input logic [13:0] pres,
                                      input logic [7:0] mk, input logic [7:0] bz);
        seek_t r;
        logic  stop;
        r.phase = PH_DONE;
        r.slot  = '0;
        r.errs  = '0;
        stop    = 1'b0;
        for (int s = 1; s <= 14; s++)
        begin
            if (!stop && (4'(s) >= from))
            begin
                if (pres[s-1] && (s != 12))
                begin
                    r.phase = PH_ITEMS;
                    r.slot  = 4'(s);
                    stop    = 1'b1;
                end
                else if (!pres[s-1])
                begin
                    if (s == 1)
                        r.errs[0] = 1'b1;
                    else if (s == 2)
                    begin
                        r.errs[1] = 1'b1;
                        r.phase   = PH_ABANDON;
                        stop      = 1'b1;
                    end
                    else if (s == 3)
                        r.errs[2] = 1'b1;
                    else if (s == 9 && mk == bz)
                        r.errs[3] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic out_word_t elem_fn(input logic [3:0] code, input logic [23:0] val,
                                          input logic last);
        out_word_t w;
        w = '0;
        w.result_kind   = KIND_ELEM;
        w.element_code  = code;
        w.element_value = val;
        w.last_in_item  = last;
        return w;
    endfunction

    function automatic out_word_t err_fn(input logic [2:0] code);
        out_word_t w;
        w = '0;
        w.result_kind = KIND_ERR;
        w.error_code  = code;
        return w;
    endfunction

    assign in_ready  = (cnt_reg <= (OBUF_AW+1)'(OBUF_DEPTH - MAX_RES));
    assign in_acc    = in_valid && in_ready;
    assign out_valid = (cnt_reg != '0);
    assign out_pop   = out_valid && out_ready;
    assign out_data  = obuf[rd_ptr_reg];

    // Byte decoder: next record state and the ordered list of results.
    always_comb
    begin
        logic [7:0]  b;
        logic [23:0] acc_n;
        logic [2:0]  idx;
        logic        done, do_seek, elem_v, fin_err;
        logic [3:0]  from;
        logic [15:0] d;
        logic [24:0] tsum;
        out_word_t   elem;
        seek_t       sr;
        out_word_t   cand [6];
        logic [5:0]  cv;
        logic [2:0]  n;

        b       = in_data.data_byte;
        acc_n   = {acc_reg[15:0], b};
        idx     = bidx_reg;
        done    = 1'b0;
        do_seek = 1'b0;
        elem_v  = 1'b0;
        from    = 4'd1;
        d       = acc_n[15:0];
        tsum    = {1'b0, acc_n} + 25'd127;
        elem    = '0;
        sr      = '{phase: PH_DONE, slot: '0, errs: '0};

        phase_next = phase_reg;
        pres_next  = pres_reg;
        slot_next  = slot_reg;
        bidx_next  = bidx_reg;
        acc_next   = acc_reg;
        rep_next   = rep_reg;
        mk_next    = mk_reg;

        if (phase_reg == PH_PRESENCE)
        begin
            if (bidx_reg == 3'd0)
                pres_next[6:0] = pres_reg[6:0] | b[7:1];
            else if (bidx_reg == 3'd1)
                pres_next[13:7] = pres_reg[13:7] | b[7:1];
            if (bidx_reg != 3'd7)
                bidx_next = bidx_reg + 3'd1;
            if (!b[0])
                do_seek = 1'b1;
        end
        else if (phase_reg == PH_ITEMS)
        begin
            acc_next  = acc_n;
            bidx_next = idx + 3'd1;
            case (slot_reg)
                4'd1:
                begin
                    elem_v = 1'b1;
                    elem   = elem_fn((idx == 3'd0) ? EL_SRC_AREA : EL_SRC_ID, {16'd0, b},
                                     idx != 3'd0);
                    done   = (idx != 3'd0);
                end
                4'd2:
                begin
                    mk_next = b;
                    elem_v  = 1'b1;
                    elem    = elem_fn(EL_MSG_TYPE, {16'd0, b}, 1'b1);
                    done    = 1'b1;
                end
                4'd3:
                begin
                    elem_v = 1'b1;
                    elem   = elem_fn(EL_SECTOR, {16'd0, b}, 1'b1);
                    done   = 1'b1;
                end
                4'd4:
                begin
                    if (idx >= 3'd2)
                    begin
                        elem_v = 1'b1;
                        elem   = elem_fn(EL_TIME, {6'd0, tsum[24:7]}, 1'b1);
                        done   = 1'b1;
                    end
                end
                4'd5:
                begin
                    if (idx >= 3'd1)
                    begin
                        elem_v = 1'b1;
                        elem   = elem_fn(EL_SPEED, {8'd0, acc_n[15:0]}, 1'b1);
                        done   = 1'b1;
                    end
                end
                4'd6, 4'd7, 4'd11:
                begin
                    elem_v = 1'b1;
                    elem   = elem_fn((slot_reg == 4'd11) ? EL_WARN :
                                     ((slot_reg == 4'd6) ? EL_CONFIG : EL_MODE),
                                     {17'd0, b[7:1]}, !b[0]);
                    done   = !b[0];
                end
                4'd8:
                begin
                    if (idx == 3'd0)
                    begin
                        rep_next  = b;
                        done      = (b == 8'd0);
                        bidx_next = 3'd1;
                    end
                    else if (idx == 3'd1)
                        bidx_next = 3'd2;
                    else
                    begin
                        rep_next  = rep_reg - 8'd1;
                        elem_v    = 1'b1;
                        elem      = elem_fn(EL_PLOTS, {14'd0, d[9:0]},
                                            rep_reg == 8'd1);
                        elem.plot_ident   = d[14:10];
                        elem.antenna_flag = d[15];
                        done      = (rep_reg == 8'd1);
                        bidx_next = 3'd1;
                    end
                end
                4'd9:
                begin
                    if (idx[0])
                    begin
                        elem_v = 1'b1;
                        elem   = elem_fn(EL_WIN_BASE + {2'd0, idx[2:1]},
                                         {8'd0, acc_n[15:0]}, idx == 3'd7);
                        done   = (idx == 3'd7);
                    end
                end
                4'd10:
                begin
                    elem_v = 1'b1;
                    elem   = elem_fn((idx == 3'd0) ? EL_RNG_ERR : EL_AZ_ERR, {16'd0, b},
                                     idx != 3'd0);
                    done   = (idx != 3'd0);
                end
                default:
                begin
                    // Special-purpose and reserved items skip by their length octet.
                    acc_next  = acc_reg;
                    bidx_next = 3'd1;
                    if (idx == 3'd0)
                    begin
                        rep_next = (b > 8'd1) ? (b - 8'd1) : 8'd0;
                        done     = (b <= 8'd1);
                    end
                    else
                    begin
                        rep_next = rep_reg - 8'd1;
                        done     = (rep_reg == 8'd1);
                    end
                end
            endcase
            if (done)
            begin
                do_seek = 1'b1;
                from    = slot_reg + 4'd1;
            end
        end

        if (do_seek)
        begin
            sr         = seek_fn(from, pres_next, mk_next, bz_reg);
            phase_next = sr.phase;
            if (sr.phase == PH_ITEMS)
            begin
                slot_next = sr.slot;
                bidx_next = '0;
                acc_next  = '0;
                rep_next  = '0;
            end
        end

        // Record end closes the record and returns the state to its reset values.
        fin_err = (phase_next == PH_PRESENCE) || (phase_next == PH_ITEMS);
        if (in_data.record_end)
        begin
            phase_next = PH_PRESENCE;
            pres_next  = '0;
            slot_next  = '0;
            bidx_next  = '0;
            acc_next   = '0;
            rep_next   = '0;
            mk_next    = '0;
        end

        // Candidate results in output order, then packed into a dense list.
        cand[0] = elem;
        cand[1] = err_fn(ERR_NO_SRC);
        cand[2] = err_fn(ERR_NO_MSG);
        cand[3] = err_fn(ERR_NO_SECTOR);
        cand[4] = err_fn(ERR_NO_WINDOW);
        cand[5] = fin_err ? err_fn(ERR_EARLY_END) : out_word_t'('0);
        if (!fin_err)
            cand[5].result_kind = KIND_END;
        cv = {in_data.record_end, sr.errs, elem_v};
        for (int i = 0; i < MAX_RES; i++)
            res_list[i] = '0;
        n = '0;
        for (int i = 0; i < 6; i++)
        begin
            if (cv[i] && n < 3'(MAX_RES))
            begin
                res_list[n[1:0]] = cand[i];
                n = n + 3'd1;
            end
        end
        res_n = n;
    end

    // Record state and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PRESENCE;
            pres_reg  <= '0;
            slot_reg  <= '0;
            bidx_reg  <= '0;
            acc_reg   <= '0;
            rep_reg   <= '0;
            mk_reg    <= '0;
            bz_reg    <= BLIND_ZONE_RESET;
        end
        else
        begin
            if (cfg_we)
                bz_reg <= cfg_data;
            if (in_acc)
            begin
                phase_reg <= phase_next;
                pres_reg  <= pres_next;
                slot_reg  <= slot_next;
                bidx_reg  <= bidx_next;
                acc_reg   <= acc_next;
                rep_reg   <= rep_next;
                mk_reg    <= mk_next;
            end
        end
    end

    // Output buffer pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (in_acc)
                wr_ptr_reg <= wr_ptr_reg + OBUF_AW'(res_n);
            if (out_pop)
                rd_ptr_reg <= rd_ptr_reg + OBUF_AW'(1);
            cnt_reg <= cnt_reg + (in_acc ? (OBUF_AW+1)'(res_n) : '0)
                       - (out_pop ? (OBUF_AW+1)'(1) : '0);
        end
    end

    // Output buffer storage.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                if (3'(i) < res_n)
                    obuf[wr_ptr_reg + OBUF_AW'(i)] <= res_list[i];
            end
        end
    end

    `RSRP_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= (OBUF_AW+1)'(OBUF_DEPTH), "output buffer overfilled")
    `RSRP_ASSERT_IMPL(a_res_bound, clk, rst_n, in_acc, res_n <= 3'(MAX_RES), "too many results for one word")
    `RSRP_ASSERT_NEXT(a_end_clears, clk, rst_n, in_acc && in_data.record_end, phase_reg == PH_PRESENCE && pres_reg == '0, "record state not cleared at end")

endmodule

@@ dv/radar_service_record_parser_checker.sv @@
// Checker for the radar service record parser: watches both channels, predicts results.
// Depends on rsrp_pkg; instantiated beside the block by the testbench top.
module radar_service_record_parser_checker
    import rsrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_word_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_word_t out_data,
    input  logic      cfg_we,
    input  logic [7:0] cfg_data,
    output int        fail_count,
    output int        pending_count
);

    typedef enum logic [1:0] {PH_PRESENCE, PH_ITEMS, PH_DONE, PH_ABANDON} phase_t;

    // Predictor copy of the decoder state.
    logic [7:0]  blind_code;
    phase_t      phase;
    logic [13:0] present;
    logic [3:0]  slot;
    logic [2:0]  pos;
    logic [23:0] acc_q;
    logic [7:0]  reps;
    logic [7:0]  msg_kind;

    out_word_t expected_words[$];

    assign pending_count = expected_words.size();

    function automatic out_word_t mk_elem(logic [3:0] code, logic [23:0] val, logic last);
        out_word_t w;
        w = '0;
        w.result_kind = KIND_ELEM;
        w.element_code = code;
        w.element_value = val;
        w.last_in_item = last;
        return w;
    endfunction

    function automatic out_word_t mk_err(logic [2:0] err);
        out_word_t w;
        w = '0;
        w.result_kind = KIND_ERR;
        w.error_code = err;
        return w;
    endfunction

    // Append one predicted word at the tail of the queue.
    function automatic void expect_word(out_word_t w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    task automatic clear_record();
        phase = PH_PRESENCE;
        present = '0;
        slot = '0;
        pos = '0;
        acc_q = '0;
        reps = '0;
        msg_kind = '0;
    endtask

    // Advance to the next present field, reporting absent mandatory ones.
    task automatic seek_field(int from);
        int s;
        logic here;
        for (s = from; s <= 14; s++)
        begin
            here = present[s-1];
            if (here && s != 12)
            begin
                slot = s[3:0];
                pos = '0;
                acc_q = '0;
                reps = '0;
                phase = PH_ITEMS;
                return;
            end
            if (!here)
            begin
                if (s == 1)
                    expect_word(mk_err(ERR_NO_SRC));
                else if (s == 2)
                begin
                    expect_word(mk_err(ERR_NO_MSG));
                    phase = PH_ABANDON;
                    return;
                end
                else if (s == 3)
                    expect_word(mk_err(ERR_NO_SECTOR));
                else if (s == 9 && msg_kind == blind_code)
                    expect_word(mk_err(ERR_NO_WINDOW));
            end
        end
        phase = PH_DONE;
    endtask

    // Decode one byte inside an item; returns 1 when the item is complete.
    function automatic logic decode_item_byte(logic [7:0] b);
        logic [2:0]  idx;
        logic [23:0] acc;
        logic [15:0] d;
        logic        done;
        idx = pos;
        acc = {acc_q[15:0], b};
        done = 1'b0;
        case (slot)
            4'd1:
            begin
                expect_word(mk_elem(idx == 0 ? EL_SRC_AREA : EL_SRC_ID,
                                    {16'd0, b}, idx != 0));
                done = idx != 0;
            end
            4'd2:
            begin
                msg_kind = b;
                expect_word(mk_elem(EL_MSG_TYPE, {16'd0, b}, 1'b1));
                done = 1'b1;
            end
            4'd3:
            begin
                expect_word(mk_elem(EL_SECTOR, {16'd0, b}, 1'b1));
                done = 1'b1;
            end
            4'd4:
                if (idx >= 2)
                begin
                    expect_word(mk_elem(EL_TIME,
                        24'((25'(acc) + 25'd127) >> 7), 1'b1));
                    done = 1'b1;
                end
            4'd5:
                if (idx >= 1)
                begin
                    expect_word(mk_elem(EL_SPEED, {8'd0, acc[15:0]}, 1'b1));
                    done = 1'b1;
                end
            4'd6, 4'd7, 4'd11:
            begin
                expect_word(mk_elem(slot == 4'd11 ? EL_WARN : slot,
                                    {17'd0, b[7:1]}, !b[0]));
                done = !b[0];
            end
            4'd8:
            begin
                if (idx == 0)
                begin
                    reps = b;
                    done = b == 0;
                    idx = 3'd1;
                end
                else if (idx == 1)
                    idx = 3'd2;
                else
                begin
                    out_word_t w;
                    d = acc[15:0];
                    reps = reps - 8'd1;
                    w = mk_elem(EL_PLOTS, {14'd0, d[9:0]}, reps == 0);
                    w.plot_ident = d[14:10];
                    w.antenna_flag = d[15];
                    expect_word(w);
                    done = reps == 0;
                    idx = 3'd1;
                end
                acc_q = acc;
                pos = idx;
                return done;
            end
            4'd9:
                if (idx[0])
                begin
                    expect_word(mk_elem(EL_WIN_BASE + 4'(idx >> 1),
                                        {8'd0, acc[15:0]}, idx >= 7));
                    done = idx >= 7;
                end
            4'd10:
            begin
                expect_word(mk_elem(idx == 0 ? EL_RNG_ERR : EL_AZ_ERR,
                                    {16'd0, b}, idx != 0));
                done = idx != 0;
            end
            default:
            begin
                if (idx == 0)
                    reps = b > 1 ? b - 8'd1 : 8'd0;
                else
                    reps = reps - 8'd1;
                done = reps == 0;
                pos = 3'd1;
                return done;
            end
        endcase
        acc_q = acc;
        pos = idx + 3'd1;
        return done;
    endfunction

    task automatic predict_byte(in_word_t w);
        logic done;
        out_word_t e;
        if (phase == PH_PRESENCE)
        begin
            if (pos < 2)
                present = present | (14'(w.data_byte[7:1]) << (7 * pos));
            if (pos < 7)
                pos = pos + 3'd1;
            if (!w.data_byte[0])
                seek_field(1);
        end
        else if (phase == PH_ITEMS)
        begin
            done = decode_item_byte(w.data_byte);
            if (done)
                seek_field(int'(slot) + 1);
        end
        if (w.record_end)
        begin
            if (phase == PH_PRESENCE || phase == PH_ITEMS)
                expect_word(mk_err(ERR_EARLY_END));
            else
            begin
                e = '0;
                e.result_kind = KIND_END;
                expect_word(e);
            end
            clear_record();
        end
    endtask

    // Sample both channels on each rising edge and compare.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blind_code <= BLIND_ZONE_RESET;
            clear_record();
            expected_words.delete();
            fail_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %p", $time,
                             out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (out_data !== expected_words[0])
                    begin
                        $display("%0t: mismatch, expected %p, actual %p", $time,
                                 expected_words[0], out_data);
                        fail_count <= fail_count + 1;
                    end
                    void'(expected_words.pop_front());
                end
            end
            if (in_valid && in_ready)
                predict_byte(in_data);
            if (cfg_we)
                blind_code <= cfg_data;
        end
    end

endmodule

@@ dv/radar_service_record_parser_tb.sv @@
// Testbench top for the radar service record parser: stimulus, idling and verdict.
// Depends on rsrp_pkg, the block and radar_service_record_parser_checker.
module radar_service_record_parser_tb;
    import rsrp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;
    logic      cfg_we;
    logic [7:0] cfg_data;
    int        fail_count;
    int        pending_count;
    int        cycle_count;
    int        bytes_sent;
    logic      quiet_phase;

    radar_service_record_parser u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    radar_service_record_parser_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Cycle limit guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver side stalls in random bursts.
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 17);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Send one word and wait for its acceptance; valid stays up between back-to-back words.
    task automatic send_word(logic [7:0] b, logic e);
        int n;
        if (!quiet_phase && $urandom_range(0, 6) == 0)
        begin
            n = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{data_byte: b, record_end: e};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_record(logic [7:0] bytes[$]);
        foreach (bytes[i])
            send_word(bytes[i], i == bytes.size() - 1);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_blind_code(logic [7:0] v);
        drain_results();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Append one byte at the tail of a record.
    function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] v);
        q.insert(q.size(), v);
    endfunction

    // Item bytes for one field with random content; field 2 carries the given message type.
    task automatic add_item(int f, ref logic [7:0] q[$], input logic [7:0] mkind);
        int k;
        int n;
        case (f)
            1: repeat (2) add_byte(q, 8'($urandom));
            2: add_byte(q, mkind);
            3: add_byte(q, 8'($urandom));
            4: repeat (3) add_byte(q, 8'($urandom));
            5: repeat (2) add_byte(q, 8'($urandom));
            6, 7, 11:
            begin
                n = $urandom_range(0, 3);
                for (k = 0; k <= n; k++)
                    add_byte(q, {7'($urandom), 1'(k < n)});
            end
            8:
            begin
                n = $urandom_range(0, 4);
                add_byte(q, 8'(n));
                repeat (2 * n) add_byte(q, 8'($urandom));
            end
            9: repeat (8) add_byte(q, 8'($urandom));
            10: repeat (2) add_byte(q, 8'($urandom));
            default:
            begin
                n = $urandom_range(0, 5);
                add_byte(q, 8'(n));
                for (k = 1; k < n; k++)
                    add_byte(q, 8'($urandom));
            end
        endcase
    endtask

    // Well-formed record from a presence map, optionally with extra presence octets.
    task automatic build_record(logic [13:0] pres, logic [7:0] mkind, int extra_fspec,
                                ref logic [7:0] q[$]);
        int f;
        q.delete();
        add_byte(q, {pres[6:0], 1'b1});
        add_byte(q, {pres[13:7], 1'(extra_fspec > 0)});
        for (f = 0; f < extra_fspec; f++)
            add_byte(q, {7'($urandom), 1'(f < extra_fspec - 1)});
        if (pres[13:7] == 0 && extra_fspec == 0 && $urandom_range(0, 1))
            q[0][0] = 1'b0;
        if (q[0][0] == 1'b0)
            void'(q.pop_back());
        for (f = 1; f <= 14; f++)
        begin
            if (pres[f-1] && f != 12)
                add_item(f, q, mkind);
            if (f == 2 && !pres[1])
                break;
        end
    endtask

    task automatic random_record();
        logic [7:0] q[$];
        logic [13:0] pres;
        logic [7:0] mkind;
        int mode;
        int k;
        pres = 14'($urandom);
        if ($urandom_range(0, 9) != 0)
            pres[1] = 1'b1;
        mkind = $urandom_range(0, 3) == 0 ? u_checker.blind_code : 8'($urandom);
        mode = $urandom_range(0, 9);
        build_record(pres, mkind, $urandom_range(0, 6) == 0 ? $urandom_range(1, 2) : 0, q);
        if (mode == 0 && q.size() > 1)
            q = q[0:$urandom_range(0, q.size() - 2)];
        else if (mode == 1)
            repeat ($urandom_range(1, 3)) add_byte(q, 8'($urandom));
        else if (mode == 2)
        begin
            q.delete();
            k = $urandom_range(1, 6);
            repeat (k) add_byte(q, 8'($urandom));
        end
        send_record(q);
    endtask

    initial
    begin
        logic [7:0] q[$];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        cycle_count = 0;
        bytes_sent = 0;
        quiet_phase = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all fields present, message type equal to the blind-zone code.
        q = '{8'hFF, 8'hFE, 8'h11, 8'h22, 8'h08, 8'h33, 8'hFF, 8'hFF, 8'hFF,
              8'h00, 8'h01, 8'h03, 8'h02, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
        send_record(q);
        // Missing source and message type; the record is abandoned.
        send_record('{8'h40, 8'h00, 8'h08, 8'h00});
        // Missing message type abandons the record.
        send_record('{8'h80, 8'hAA, 8'hBB, 8'hCC});
        // Early end inside the presence octets; then missing source and message type.
        send_record('{8'hE1});
        send_record('{8'hE0, 8'h01, 8'h02});
        // Two presence octets without source or message type; the record is abandoned.
        send_record('{8'h61, 8'h1E, 8'h05, 8'h00, 8'h00, 8'h01, 8'h7F});

        write_blind_code(8'h00);
        repeat (6) random_record();
        write_blind_code(8'hFF);
        repeat (4) random_record();

        // Sender holds off until every expected word has arrived.
        drain_results();
        write_blind_code(8'($urandom));
        while (bytes_sent < 390)
            random_record();
        write_blind_code(u_checker.blind_code);

        quiet_phase = 1'b1;
        repeat (4) random_record();

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
